@@ rtl/periodic_timer_table_defines.svh @@
// Assertion macros shared by the timer table RTL.
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

// The antecedent in one cycle implies the consequent in the next, outside reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

// The antecedent implies the consequent in the same cycle, outside reset.
`define PTT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// The condition holds in the cycle after reset.
`define PTT_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("timer table reset assertion failed");

`endif

@@ rtl/ptt_pkg.sv @@
// Shared constants, codes and control types of the timer table.
package ptt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int TIME_W     = 48;
  localparam int ID_W       = 32;
  localparam int IVL_W      = 32;
  localparam int DIV_CNT_W  = $clog2(TIME_W);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_STOP    = 2'd1;
  localparam logic [1:0] CMD_PROCESS = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_STOPPED = 3'd1;
  localparam logic [2:0] KIND_FIRED   = 3'd2;
  localparam logic [2:0] KIND_NOTHING = 3'd3;
  localparam logic [2:0] KIND_NEXT    = 3'd4;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic             latch;
    logic             do_start;
    logic             stop_clr;
    logic             oneshot_clr;
    logic             div_go;
    logic             div_step;
    logic             dl_write;
    logic             qry_acc;
    logic             cp_copy;
    logic             cp_commit;
    logic             pend_load;
    logic [2:0]       pend_kind;
    logic             pend_status;
    logic             out_push;
    logic             out_last;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] new_count;
  } ptt_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             id_match;
    logic             active;
    logic             due;
    logic             periodic;
  } ptt_stat_t;

endpackage

@@ rtl/ptt_datapath.sv @@
// Timer table storage, modulo unit, query minimum and result registers.
module ptt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ptt_pkg::ptt_ctl_t            ctl,
  output ptt_pkg::ptt_stat_t           st,
  input  logic [ptt_pkg::TIME_W-1:0]   now,
  input  logic [ptt_pkg::IVL_W-1:0]    interval_ms,
  input  logic                         periodic,
  input  logic [ptt_pkg::ID_W-1:0]     target_id,
  output logic                         done,
  output logic [2:0]                   kind,
  output logic                         status,
  output logic [ptt_pkg::ID_W-1:0]     timer_id,
  output logic [ptt_pkg::TIME_W-1:0]   remaining_ms,
  output logic                         none_pending,
  output logic                         last
);

  logic                         periodic_r [ptt_pkg::NUM_TIMERS];
  logic [ptt_pkg::ID_W-1:0]     id_r       [ptt_pkg::NUM_TIMERS];
  logic [ptt_pkg::IVL_W-1:0]    intv_r     [ptt_pkg::NUM_TIMERS];
  logic [ptt_pkg::TIME_W-1:0]   dl_r       [ptt_pkg::NUM_TIMERS];
  logic [ptt_pkg::NUM_TIMERS-1:0] active;
  logic [ptt_pkg::CNT_W-1:0]    count;
  logic [ptt_pkg::ID_W-1:0]     id_ctr;

  logic [ptt_pkg::TIME_W-1:0]   now_q;
  logic [ptt_pkg::IVL_W-1:0]    ival_q;
  logic                         per_q;
  logic [ptt_pkg::ID_W-1:0]     target_q;

  logic [ptt_pkg::TIME_W-1:0]   dvd;
  logic [ptt_pkg::IVL_W-1:0]    rem;
  logic [ptt_pkg::IVL_W-1:0]    div_iv;

  logic [ptt_pkg::TIME_W-1:0]   best;
  logic                         any;

  logic [2:0]                   pend_kind;
  logic                         pend_status;
  logic [ptt_pkg::ID_W-1:0]     pend_id;
  logic [ptt_pkg::TIME_W-1:0]   pend_rem;
  logic                         pend_none;

  logic                         rd_per;
  logic [ptt_pkg::ID_W-1:0]     rd_id;
  logic [ptt_pkg::IVL_W-1:0]    rd_iv;
  logic [ptt_pkg::TIME_W-1:0]   rd_dl;
  logic                         rd_act;
  logic [ptt_pkg::TIME_W:0]     start_sum;
  logic [ptt_pkg::TIME_W-1:0]   start_dl;
  logic [ptt_pkg::IVL_W:0]      rem_sh;
  logic [ptt_pkg::IVL_W:0]      rem_sub;
  logic [ptt_pkg::TIME_W:0]     adv_sum;
  logic [ptt_pkg::TIME_W-1:0]   adv_dl;
  logic [ptt_pkg::ID_W-1:0]     id_sel;
  logic [ptt_pkg::TIME_W-1:0]   qry_rem;

  assign rd_per = periodic_r[ctl.rd_idx];
  assign rd_id  = id_r[ctl.rd_idx];
  assign rd_iv  = intv_r[ctl.rd_idx];
  assign rd_dl  = dl_r[ctl.rd_idx];
  assign rd_act = active[ctl.rd_idx];

  assign st.count    = count;
  assign st.full     = (count == ptt_pkg::CNT_W'(ptt_pkg::NUM_TIMERS));
  assign st.id_match = (rd_id == target_q);
  assign st.active   = rd_act;
  assign st.due      = rd_act && (rd_dl <= now_q);
  assign st.periodic = rd_per;

  // Saturating deadline for a new timer.
  assign start_sum = {1'b0, now_q} + {{(ptt_pkg::TIME_W + 1 - ptt_pkg::IVL_W){1'b0}}, ival_q};
  assign start_dl  = start_sum[ptt_pkg::TIME_W] ? ptt_pkg::TIME_MAX
                                                : start_sum[ptt_pkg::TIME_W-1:0];

  // One restoring step of (now - deadline) mod interval.
  assign rem_sh  = {rem, dvd[ptt_pkg::TIME_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_iv};

  // Next deadline past now: now - rem + interval, saturated.
  assign adv_sum = {1'b0, now_q}
                 - {{(ptt_pkg::TIME_W + 1 - ptt_pkg::IVL_W){1'b0}}, rem}
                 + {{(ptt_pkg::TIME_W + 1 - ptt_pkg::IVL_W){1'b0}}, div_iv};
  assign adv_dl  = adv_sum[ptt_pkg::TIME_W] ? ptt_pkg::TIME_MAX
                                            : adv_sum[ptt_pkg::TIME_W-1:0];

  assign qry_rem = (best <= now_q) ? '0 : (best - now_q);

  always_comb begin
    id_sel = '0;
    if (ctl.pend_kind == ptt_pkg::KIND_FIRED) begin
      id_sel = rd_id;
    end else if (ctl.pend_kind == ptt_pkg::KIND_STARTED && ctl.pend_status == ptt_pkg::ST_OK) begin
      id_sel = id_ctr;
    end
  end

  // Control state of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      count  <= '0;
      id_ctr <= ptt_pkg::ID_W'(1);
      done   <= 1'b0;
    end else begin
      done <= ctl.out_push;
      if (ctl.do_start && !st.full) begin
        active[count[ptt_pkg::IDX_W-1:0]] <= 1'b1;
        count  <= count + 1'b1;
        id_ctr <= id_ctr + 1'b1;
      end
      if (ctl.stop_clr || ctl.oneshot_clr) begin
        active[ctl.rd_idx] <= 1'b0;
      end
      if (ctl.cp_copy) begin
        active[ctl.wr_idx] <= 1'b1;
      end
      if (ctl.cp_commit) begin
        count <= ctl.new_count;
        for (int k = 0; k < ptt_pkg::NUM_TIMERS; k++) begin
          if (ptt_pkg::CNT_W'(k) >= ctl.new_count) begin
            active[k] <= 1'b0;
          end
        end
      end
    end
  end

  // Table payload: start writes, deadline advance, compaction copy.
  always_ff @(posedge clk) begin
    if (ctl.do_start && !st.full) begin
      periodic_r[count[ptt_pkg::IDX_W-1:0]] <= per_q;
      id_r[count[ptt_pkg::IDX_W-1:0]]       <= id_ctr;
      intv_r[count[ptt_pkg::IDX_W-1:0]]     <= ival_q;
      dl_r[count[ptt_pkg::IDX_W-1:0]]       <= start_dl;
    end else if (ctl.dl_write) begin
      dl_r[ctl.rd_idx] <= adv_dl;
    end else if (ctl.cp_copy) begin
      periodic_r[ctl.wr_idx] <= rd_per;
      id_r[ctl.wr_idx]       <= rd_id;
      intv_r[ctl.wr_idx]     <= rd_iv;
      dl_r[ctl.wr_idx]       <= rd_dl;
    end
  end

  // Command word, modulo unit, query minimum and results.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      now_q    <= now;
      ival_q   <= (interval_ms == '0) ? ptt_pkg::IVL_W'(1) : interval_ms;
      per_q    <= periodic;
      target_q <= target_id;
      any      <= 1'b0;
      best     <= '0;
    end
    if (ctl.div_go) begin
      dvd    <= now_q - rd_dl;
      rem    <= '0;
      div_iv <= rd_iv;
    end else if (ctl.div_step) begin
      dvd <= {dvd[ptt_pkg::TIME_W-2:0], 1'b0};
      rem <= rem_sub[ptt_pkg::IVL_W] ? rem_sh[ptt_pkg::IVL_W-1:0]
                                     : rem_sub[ptt_pkg::IVL_W-1:0];
    end
    if (ctl.qry_acc && rd_act && (!any || rd_dl < best)) begin
      best <= rd_dl;
      any  <= 1'b1;
    end
    if (ctl.out_push) begin
      kind         <= pend_kind;
      status       <= pend_status;
      timer_id     <= pend_id;
      remaining_ms <= pend_rem;
      none_pending <= pend_none;
      last         <= ctl.out_last;
    end
    if (ctl.pend_load) begin
      pend_kind   <= ctl.pend_kind;
      pend_status <= ctl.pend_status;
      pend_id     <= id_sel;
      pend_rem    <= (ctl.pend_kind == ptt_pkg::KIND_NEXT && any) ? qry_rem : '0;
      pend_none   <= (ctl.pend_kind == ptt_pkg::KIND_NEXT) && !any;
    end
  end

endmodule

@@ rtl/ptt_ctrl.sv @@
// Command sequencer of the timer table: slot scans, modulo steps, compaction.
module ptt_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [1:0]               cmd,
  output logic                     busy,
  input  ptt_pkg::ptt_stat_t       st,
  output ptt_pkg::ptt_ctl_t        ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_STOP, S_PROC, S_DIV, S_CMPCT, S_QRY, S_FIN
  } state_t;

  state_t                      state, state_next;
  logic [ptt_pkg::CNT_W-1:0]   i, i_next;
  logic [ptt_pkg::CNT_W-1:0]   w, w_next;
  logic [ptt_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                        have_pend, have_pend_next;
  logic                        in_range;

  assign busy     = (state != S_IDLE);
  assign in_range = (i < st.count);

  always_comb begin
    ctl            = '0;
    ctl.rd_idx     = i[ptt_pkg::IDX_W-1:0];
    ctl.wr_idx     = w[ptt_pkg::IDX_W-1:0];
    ctl.new_count  = w;
    state_next     = state;
    i_next         = i;
    w_next         = w;
    div_cnt_next   = div_cnt;
    have_pend_next = have_pend;
    unique case (state)
      S_IDLE: begin
        i_next         = '0;
        w_next         = '0;
        have_pend_next = 1'b0;
        if (start) begin
          ctl.latch = 1'b1;
          unique case (cmd)
            ptt_pkg::CMD_START:   state_next = S_START;
            ptt_pkg::CMD_STOP:    state_next = S_STOP;
            ptt_pkg::CMD_PROCESS: state_next = S_PROC;
            default:              state_next = S_QRY;
          endcase
        end
      end
      S_START: begin
        ctl.do_start    = 1'b1;
        ctl.pend_load   = 1'b1;
        ctl.pend_kind   = ptt_pkg::KIND_STARTED;
        ctl.pend_status = st.full ? ptt_pkg::ST_FAIL : ptt_pkg::ST_OK;
        state_next      = S_FIN;
      end
      S_STOP: begin
        if (!in_range) begin
          ctl.pend_load   = 1'b1;
          ctl.pend_kind   = ptt_pkg::KIND_STOPPED;
          ctl.pend_status = ptt_pkg::ST_FAIL;
          state_next      = S_FIN;
        end else if (st.id_match) begin
          ctl.stop_clr    = 1'b1;
          ctl.pend_load   = 1'b1;
          ctl.pend_kind   = ptt_pkg::KIND_STOPPED;
          ctl.pend_status = ptt_pkg::ST_OK;
          state_next      = S_FIN;
        end else begin
          i_next = i + 1'b1;
        end
      end
      S_PROC: begin
        if (!in_range) begin
          i_next     = '0;
          w_next     = '0;
          state_next = S_CMPCT;
        end else if (st.due) begin
          // Release the previous fired word before holding this one.
          ctl.out_push    = have_pend;
          ctl.pend_load   = 1'b1;
          ctl.pend_kind   = ptt_pkg::KIND_FIRED;
          ctl.pend_status = ptt_pkg::ST_OK;
          have_pend_next  = 1'b1;
          if (st.periodic) begin
            ctl.div_go   = 1'b1;
            div_cnt_next = '0;
            state_next   = S_DIV;
          end else begin
            ctl.oneshot_clr = 1'b1;
            i_next          = i + 1'b1;
          end
        end else begin
          i_next = i + 1'b1;
        end
      end
      S_DIV: begin
        if (div_cnt == ptt_pkg::DIV_CNT_W'(ptt_pkg::TIME_W)) begin
          ctl.dl_write = 1'b1;
          i_next       = i + 1'b1;
          state_next   = S_PROC;
        end else begin
          ctl.div_step = 1'b1;
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      S_CMPCT: begin
        if (!in_range) begin
          ctl.cp_commit = 1'b1;
          if (!have_pend) begin
            ctl.pend_load   = 1'b1;
            ctl.pend_kind   = ptt_pkg::KIND_NOTHING;
            ctl.pend_status = ptt_pkg::ST_OK;
          end
          state_next = S_FIN;
        end else begin
          if (st.active) begin
            ctl.cp_copy = 1'b1;
            w_next      = w + 1'b1;
          end
          i_next = i + 1'b1;
        end
      end
      S_QRY: begin
        if (!in_range) begin
          ctl.pend_load   = 1'b1;
          ctl.pend_kind   = ptt_pkg::KIND_NEXT;
          ctl.pend_status = ptt_pkg::ST_OK;
          state_next      = S_FIN;
        end else begin
          ctl.qry_acc = 1'b1;
          i_next      = i + 1'b1;
        end
      end
      S_FIN: begin
        ctl.out_push  = 1'b1;
        ctl.out_last  = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i         <= '0;
      w         <= '0;
      div_cnt   <= '0;
      have_pend <= 1'b0;
    end else begin
      state     <= state_next;
      i         <= i_next;
      w         <= w_next;
      div_cnt   <= div_cnt_next;
      have_pend <= have_pend_next;
    end
  end

endmodule

@@ rtl/periodic_timer_table.sv @@
// Top level of the periodic and one-shot millisecond timer table.
//
// Command port: a word is taken when start is high and busy is low; cmd picks
// start, stop, process or query, with now, interval_ms, periodic and target_id
// alongside. busy stays high until the last result word is on the outputs.
// Results appear for one cycle each with done high; last marks the final word
// of a command. The receiver cannot stall, so no result is ever held back.
// Command sequence, from the accepting edge to the edge that takes the last word:
// start passes S_START and S_FIN; stop and query scan the used slots one per
// cycle, then pass S_FIN. Process scans the slots, runs each due periodic
// timer through the bit-serial modulo unit (one dividend bit per cycle), then
// compacts in a second scan and passes S_FIN.
// busy drops while the last word is shown, so the next command can be taken
// at the edge that ends it.
// Fired words of a process go out while the scan runs, one word behind; the last one goes out in S_FIN.
// Reset empties the table, clears all timers and restarts ids at one.
`include "periodic_timer_table_defines.svh"

module periodic_timer_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd,
  input  logic [ptt_pkg::TIME_W-1:0] now,
  input  logic [ptt_pkg::IVL_W-1:0]  interval_ms,
  input  logic                       periodic,
  input  logic [ptt_pkg::ID_W-1:0]   target_id,
  output logic                       done,
  output logic [2:0]                 kind,
  output logic                       status,
  output logic [ptt_pkg::ID_W-1:0]   timer_id,
  output logic [ptt_pkg::TIME_W-1:0] remaining_ms,
  output logic                       none_pending,
  output logic                       last
);

  ptt_pkg::ptt_ctl_t  ctl;
  ptt_pkg::ptt_stat_t st;

  ptt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  ptt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .now          (now),
    .interval_ms  (interval_ms),
    .periodic     (periodic),
    .target_id    (target_id),
    .done         (done),
    .kind         (kind),
    .status       (status),
    .timer_id     (timer_id),
    .remaining_ms (remaining_ms),
    .none_pending (none_pending),
    .last         (last)
  );

  `PTT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PTT_ASSERT_NOW(a_mid_word_busy, done && !last, busy)
  `PTT_ASSERT_RST(a_reset_idle, !busy && !done)

endmodule
